// ===== rtl/lcd_seq_pkg.sv =====
package lcd_seq_pkg;

  localparam int ROW_SLOTS = 4;

  // opcodes
  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_GLYPH = 3'd1;
  localparam logic [2:0] OP_GOTO  = 3'd2;
  localparam logic [2:0] OP_PUT   = 3'd3;
  localparam logic [2:0] OP_PRINT = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;

  // configuration register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // command classes handed from front to back
  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_GLYPH = 2'd1;
  localparam logic [1:0] KIND_ONE   = 2'd2;
  localparam logic [1:0] KIND_PAIR  = 2'd3;

  localparam logic [7:0] CMD_CGRAM     = 8'h40;
  localparam logic [7:0] CMD_DDRAM     = 8'h80;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] LINE2_BASE    = 8'h40;
  localparam logic [2:0] CLEAR_WAIT_MS = 3'd3;
  localparam logic [5:0] POWERON_MS    = 6'd50;
  localparam logic [3:0] SEQ_LAST_IDX  = 4'd8;

  typedef struct packed {
    logic [1:0] kind;
    logic       rs0;
    logic [7:0] byte0;
    logic [2:0] after0;
    logic [7:0] byte1;
    logic [2:0] glyph;
  } cmd_t;

  localparam logic [4:0] GLYPH_ROM [8][8] = '{
    '{5'h07, 5'h0F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F},
    '{5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h0F, 5'h07},
    '{5'h1C, 5'h1E, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F},
    '{5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1E, 5'h1C},
    '{5'h1F, 5'h1F, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    '{5'h1F, 5'h1F, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h1F},
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h1F, 5'h1F},
    '{5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F}
  };

  // power-up sequence: three 8-bit-mode nibbles, a 4-bit-mode nibble, then function set, display off,
  // clear, entry mode, display on
  function automatic logic [7:0] init_value(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0, 4'd1, 4'd2: v = 8'b0000_0011;
      4'd3:             v = 8'b0000_0010;
      4'd4:             v = 8'b0010_1000;
      4'd5:             v = 8'b0000_1000;
      4'd6:             v = 8'h01;
      4'd7:             v = 8'b0000_0110;
      4'd8:             v = 8'b0000_1100;
      default:          v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] init_after(input logic [3:0] idx);
    logic [2:0] a;
    case (idx)
      4'd0:    a = 3'd5;
      4'd4:    a = 3'd0;
      4'd6:    a = 3'd3;
      4'd1, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8: a = 3'd1;
      default: a = 3'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/char_lcd_command_sequencer.sv =====
// An accepted item is queued, and the back end registers each of its transfers at the output.
// The back end issues one transfer per cycle while the output is not stalled; an item has
// 1 transfer (goto, put, clear), 2 (print) or 9 (init, glyph).
// The front end takes an item per cycle until the two-entry command queue is full.
// Reset (synchronous, rst_n low): queue and output empty, cursor at 0,0,
// columns 16, rows 2.
module char_lcd_command_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_opcode,
  input  logic [7:0] in_data_byte,
  input  logic [5:0] in_column,
  input  logic [2:0] in_row,
  input  logic [2:0] in_glyph_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_reg_select,
  output logic [7:0] out_value,
  output logic       out_nibble_only,
  output logic [5:0] out_wait_before_ms,
  output logic [2:0] out_wait_after_ms,
  output logic       out_last
);

  lcd_seq_pkg::cmd_t wr_cmd, rd_cmd;
  logic       acc, push, full, rd_valid, pop;
  logic [1:0] q_count;

  assign in_stall = full;
  assign acc      = in_valid && !in_stall;

  lcd_seq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .opcode      (in_opcode),
    .data_byte   (in_data_byte),
    .column      (in_column),
    .row         (in_row),
    .glyph_index (in_glyph_index),
    .push        (push),
    .cmd         (wr_cmd)
  );

  lcd_seq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_cmd   (wr_cmd),
    .full     (full),
    .rd_valid (rd_valid),
    .rd_cmd   (rd_cmd),
    .pop      (pop),
    .count    (q_count)
  );

  lcd_seq_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (rd_valid),
    .cmd                (rd_cmd),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_reg_select     (out_reg_select),
    .out_value          (out_value),
    .out_nibble_only    (out_nibble_only),
    .out_wait_before_ms (out_wait_before_ms),
    .out_wait_after_ms  (out_wait_after_ms),
    .out_last           (out_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_count != 2'd2))
    else $error("command queue written while full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_count != 2'd3)
    else $error("command queue count out of range");

  a_nibble_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_nibble_only) |-> (!out_reg_select && out_value[7:4] == 4'h0))
    else $error("nibble transfer not a command nibble");

  a_poweron_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wait_before_ms != 6'd0) |-> (out_nibble_only && !out_last))
    else $error("power-on wait outside the first init nibble");

endmodule

// ===== rtl/lcd_seq_front.sv =====
module lcd_seq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [5:0]          cfg_wdata,
  input  logic                acc,
  input  logic [2:0]          opcode,
  input  logic [7:0]          data_byte,
  input  logic [5:0]          column,
  input  logic [2:0]          row,
  input  logic [2:0]          glyph_index,
  output logic                push,
  output lcd_seq_pkg::cmd_t   cmd
);

  logic [5:0] columns_r, columns_nxt;
  logic [2:0] rows_r, rows_nxt;
  logic [5:0] cur_col_r, cur_col_nxt;
  logic [2:0] cur_row_r, cur_row_nxt;

  logic [5:0] goto_col;
  logic [2:0] goto_row;
  logic [5:0] pr_col;
  logic [2:0] pr_row;
  logic [5:0] addr_col;
  logic [2:0] addr_row;
  logic [7:0] base;
  logic [7:0] ddram;

  // clamp an out-of-range position to zero
  always_comb begin
    goto_col = (column >= columns_r) ? 6'd0 : column;
    goto_row = (row >= rows_r || row >= 3'(lcd_seq_pkg::ROW_SLOTS)) ? 3'd0 : row;
  end

  // print cursor wrap
  always_comb begin
    pr_col = cur_col_r;
    pr_row = cur_row_r;
    if (cur_col_r >= columns_r && cur_row_r >= rows_r) begin
      pr_col = 6'd0;
      pr_row = 3'd0;
    end else if (cur_col_r >= columns_r) begin
      pr_col = 6'd0;
      pr_row = cur_row_r + 3'd1;
    end
  end

  always_comb begin
    if (opcode == lcd_seq_pkg::OP_PRINT) begin
      addr_col = (pr_col >= columns_r) ? 6'd0 : pr_col;
      addr_row = (pr_row >= rows_r || pr_row >= 3'(lcd_seq_pkg::ROW_SLOTS)) ? 3'd0 : pr_row;
    end else begin
      addr_col = goto_col;
      addr_row = goto_row;
    end
    case (addr_row)
      3'd1:    base = lcd_seq_pkg::LINE2_BASE;
      3'd2:    base = {2'b00, columns_r};
      3'd3:    base = lcd_seq_pkg::LINE2_BASE + {2'b00, columns_r};
      default: base = 8'h00;
    endcase
    ddram = lcd_seq_pkg::CMD_DDRAM | (base + {2'b00, addr_col});
  end

  always_comb begin
    cmd         = '0;
    cmd.byte1   = data_byte;
    cmd.glyph   = glyph_index;
    push        = acc;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    case (opcode)
      lcd_seq_pkg::OP_INIT: begin
        cmd.kind    = lcd_seq_pkg::KIND_INIT;
        cur_col_nxt = 6'd0;
        cur_row_nxt = 3'd0;
      end
      lcd_seq_pkg::OP_GLYPH: begin
        cmd.kind  = lcd_seq_pkg::KIND_GLYPH;
        cmd.byte0 = lcd_seq_pkg::CMD_CGRAM | {2'b00, glyph_index, 3'b000};
      end
      lcd_seq_pkg::OP_GOTO: begin
        cmd.kind    = lcd_seq_pkg::KIND_ONE;
        cmd.byte0   = ddram;
        cur_col_nxt = goto_col;
        cur_row_nxt = goto_row;
      end
      lcd_seq_pkg::OP_PUT: begin
        cmd.kind  = lcd_seq_pkg::KIND_ONE;
        cmd.rs0   = 1'b1;
        cmd.byte0 = data_byte;
      end
      lcd_seq_pkg::OP_PRINT: begin
        cmd.kind    = lcd_seq_pkg::KIND_PAIR;
        cmd.byte0   = ddram;
        cur_col_nxt = pr_col + 6'd1;
        cur_row_nxt = pr_row;
      end
      lcd_seq_pkg::OP_CLEAR: begin
        cmd.kind    = lcd_seq_pkg::KIND_ONE;
        cmd.byte0   = lcd_seq_pkg::CMD_CLEAR;
        cmd.after0  = lcd_seq_pkg::CLEAR_WAIT_MS;
        cur_col_nxt = 6'd0;
        cur_row_nxt = 3'd0;
      end
      default: begin
        // unknown opcodes are swallowed
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    columns_nxt = columns_r;
    rows_nxt    = rows_r;
    if (cfg_we) begin
      if (cfg_index == lcd_seq_pkg::CFG_COLUMNS) begin
        columns_nxt = cfg_wdata;
      end else begin
        rows_nxt = cfg_wdata[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= 6'd16;
      rows_r    <= 3'd2;
      cur_col_r <= 6'd0;
      cur_row_r <= 3'd0;
    end else begin
      columns_r <= columns_nxt;
      rows_r    <= rows_nxt;
      if (acc) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
      end
    end
  end

endmodule

// ===== rtl/lcd_seq_fifo.sv =====
module lcd_seq_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcd_seq_pkg::cmd_t wr_cmd,
  output logic              full,
  output logic              rd_valid,
  output lcd_seq_pkg::cmd_t rd_cmd,
  input  logic              pop,
  output logic [1:0]        count
);

  lcd_seq_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_cmd   = mem_r[rd_ptr_r];
  assign count    = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

endmodule

// ===== rtl/lcd_seq_back.sv =====
module lcd_seq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  lcd_seq_pkg::cmd_t cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_reg_select,
  output logic [7:0]        out_value,
  output logic              out_nibble_only,
  output logic [5:0]        out_wait_before_ms,
  output logic [2:0]        out_wait_after_ms,
  output logic              out_last
);

  logic [3:0] idx_r, idx_nxt;
  logic       valid_r;
  logic       rs_r, nib_r, last_r;
  logic [7:0] val_r;
  logic [5:0] before_r;
  logic [2:0] after_r;

  logic       rs, nib, last;
  logic [7:0] val;
  logic [5:0] pre_ms;
  logic [2:0] after;
  logic       ld;
  logic [2:0] grow;

  assign grow = 3'(idx_r - 4'd1);

  // transfer number idx_r of the command at the queue head
  always_comb begin
    rs     = 1'b0;
    val    = cmd.byte0;
    nib    = 1'b0;
    pre_ms = 6'd0;
    after  = 3'd0;
    last   = 1'b0;
    case (cmd.kind)
      lcd_seq_pkg::KIND_INIT: begin
        val    = lcd_seq_pkg::init_value(idx_r);
        nib    = (idx_r < 4'd4);
        pre_ms = (idx_r == 4'd0) ? lcd_seq_pkg::POWERON_MS : 6'd0;
        after  = lcd_seq_pkg::init_after(idx_r);
        last   = (idx_r == lcd_seq_pkg::SEQ_LAST_IDX);
      end
      lcd_seq_pkg::KIND_GLYPH: begin
        if (idx_r != 4'd0) begin
          rs  = 1'b1;
          val = {3'b000, lcd_seq_pkg::GLYPH_ROM[cmd.glyph][grow]};
        end
        last = (idx_r == lcd_seq_pkg::SEQ_LAST_IDX);
      end
      lcd_seq_pkg::KIND_ONE: begin
        rs    = cmd.rs0;
        after = cmd.after0;
        last  = 1'b1;
      end
      lcd_seq_pkg::KIND_PAIR: begin
        if (idx_r != 4'd0) begin
          rs  = 1'b1;
          val = cmd.byte1;
        end
        last = (idx_r != 4'd0);
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  assign ld  = cmd_valid && (!valid_r || !out_stall);
  assign pop = ld && last;

  always_comb begin
    idx_nxt = idx_r;
    if (ld) begin
      idx_nxt = last ? 4'd0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      rs_r     <= rs;
      val_r    <= val;
      nib_r    <= nib;
      before_r <= pre_ms;
      after_r  <= after;
      last_r   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 4'd0;
    end else begin
      idx_r <= idx_nxt;
      if (ld) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_reg_select     = rs_r;
  assign out_value          = val_r;
  assign out_nibble_only    = nib_r;
  assign out_wait_before_ms = before_r;
  assign out_wait_after_ms  = after_r;
  assign out_last           = last_r;

endmodule
